>>> design/lru_page_replacement_defines.svh
// Assertion macros used by the top design file.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define LRUPR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lrupr: same-cycle check failed");
// ante holds -> cons holds in the next cycle
`define LRUPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lrupr: next-cycle check failed");
`else
`define LRUPR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LRUPR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> design/lrupr_pkg.sv
package lrupr_pkg;

    // default geometry
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    // fixed port widths
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int TOTAL_W = 32;

    // register port
    localparam int CFG_W     = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [CFG_W-1:0]     CFG_RESET         = 5'd16;
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

    // one result beat
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [TOTAL_W-1:0] fault_total;
        logic [TOTAL_W-1:0] hit_total;
    } t_res;

endpackage

>>> design/lrupr_cell.sv
module lrupr_cell #(
    parameter int  PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int  INDEX     = 0,
    parameter int  IDX_W     = 4,
    parameter int  CNT_W     = 5,
    parameter type t_scan    = logic,
    parameter type t_upd     = logic
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PAGE_BITS-1:0] i_key,
    input  logic [CNT_W-1:0]     i_used,
    input  logic                 i_tok_valid,
    input  t_scan                i_tok,
    output logic                 o_tok_valid,
    output t_scan                o_tok,
    input  t_upd                 i_upd
);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [IDX_W-1:0]     r_rank;
    logic                 r_tok_valid;
    t_scan                r_tok;
    t_scan                n_tok;
    logic                 w_in_use;
    logic                 w_match;

    // frame takes part only below the count in use
    assign w_in_use = (CNT_W'(INDEX) < i_used);
    assign w_match  = w_in_use && r_valid && (r_page == i_key);

    // fold this frame into the passing search record
    always_comb begin
        n_tok = i_tok;
        if (w_match && !i_tok.hit_found) begin
            n_tok.hit_found = 1'b1;
            n_tok.hit_idx   = IDX_W'(INDEX);
            n_tok.hit_rank  = r_rank;
        end
        if (w_in_use && !r_valid && !i_tok.empty_found) begin
            n_tok.empty_found = 1'b1;
            n_tok.empty_idx   = IDX_W'(INDEX);
        end
        if (w_in_use && (!i_tok.best_have || (r_rank > i_tok.best_rank))) begin
            n_tok.best_have = 1'b1;
            n_tok.best_idx  = IDX_W'(INDEX);
            n_tok.best_rank = r_rank;
            n_tok.best_page = r_page;
        end
    end

    // token handoff to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_valid) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

    // frame valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd.en && (i_upd.idx == IDX_W'(INDEX))) begin
            r_valid <= 1'b1;
        end
    end

    // page and recency rank; frames more recent than the used one age by one
    always_ff @(posedge i_clk) begin
        if (i_upd.en) begin
            if (i_upd.idx == IDX_W'(INDEX)) begin
                r_rank <= '0;
                if (i_upd.fill) begin
                    r_page <= i_upd.page;
                end
            end else if (r_valid && (!i_upd.old_valid || (r_rank < i_upd.old_rank))) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

endmodule

>>> design/lru_page_replacement.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------------
// page in  | i_valid / o_ready   | i_page
// result   | o_valid / i_ready   | o_hit o_slot o_evicted_valid o_evicted_page
//          |                     | o_fault_total o_hit_total
// register | psel penable pwrite | paddr pwdata prdata, pready tied high
//
// For each reference a search record walks the row of frame cells one cell per
// cycle; the choice is then settled into registers, and a write step updates the
// frames, totals and result register. The next reference is taken in that write
// step. Reset (synchronous) empties all frames and zeroes both totals.
// A result held by i_ready low stalls only the write step; one waiting result
// and one searching reference can be in flight together.
module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // page reference
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lrupr_pkg::PAGE_W-1:0]        i_page,
    // result
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]        o_slot,
    output logic                                o_evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]        o_evicted_page,
    output logic [lrupr_pkg::TOTAL_W-1:0]       o_fault_total,
    output logic [lrupr_pkg::TOTAL_W-1:0]       o_hit_total,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrupr_pkg::ADDR_W-1:0]        paddr,
    input  logic [lrupr_pkg::DATA_W-1:0]        pwdata,
    output logic [lrupr_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    import lrupr_pkg::*;

    `include "lru_page_replacement_defines.svh"

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    typedef struct packed {
        logic                 hit_found;
        logic [IDX_W-1:0]     hit_idx;
        logic [IDX_W-1:0]     hit_rank;
        logic                 empty_found;
        logic [IDX_W-1:0]     empty_idx;
        logic                 best_have;
        logic [IDX_W-1:0]     best_idx;
        logic [IDX_W-1:0]     best_rank;
        logic [PAGE_BITS-1:0] best_page;
    } t_scan;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic                 old_valid;
        logic [IDX_W-1:0]     old_rank;
        logic                 fill;
        logic [PAGE_BITS-1:0] page;
    } t_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic                 r_start;
    logic [CFG_W-1:0]     r_cfg;
    logic [PAGE_BITS-1:0] r_key;
    logic                 r_hit;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_old_valid;
    logic [IDX_W-1:0]     r_old_rank;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;
    logic                 r_out_valid;
    t_res                 r_out;
    logic [TOTAL_W-1:0]   r_fault_cnt;
    logic [TOTAL_W-1:0]   r_hit_cnt;
    logic [TOTAL_W-1:0]   n_fault_cnt;
    logic [TOTAL_W-1:0]   n_hit_cnt;

    logic                 w_accept;
    logic                 w_apply;
    logic                 w_cfg_wr;
    logic [CNT_W-1:0]     w_used;
    logic                 w_last_valid;
    t_scan                w_last;
    t_upd                 w_upd;
    logic                 w_tok_valid [FRAMES+1];
    t_scan                w_tok       [FRAMES+1];

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[ADDR_W-1] == REG_FRAMES_IN_USE);
    assign prdata   = (paddr[ADDR_W-1] == REG_FRAMES_IN_USE) ? DATA_W'(r_cfg) : '0;

    // frames in use, clamped to 1..FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            w_used = CNT_W'(1);
        end else if (int'(r_cfg) > FRAMES) begin
            w_used = CNT_W'(FRAMES);
        end else begin
            w_used = CNT_W'(r_cfg);
        end
    end

    // handshakes
    assign w_apply  = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign o_ready  = (r_state == S_IDLE) || w_apply;
    assign w_accept = i_valid && o_ready;

    // row of frame cells; search record enters at cell 0
    assign w_tok_valid[0] = r_start;
    assign w_tok[0]       = '0;

    for (genvar k = 0; k < FRAMES; k++) begin : g_cell
        lrupr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .INDEX     (k),
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .t_scan    (t_scan),
            .t_upd     (t_upd)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_used      (w_used),
            .i_tok_valid (w_tok_valid[k]),
            .i_tok       (w_tok[k]),
            .o_tok_valid (w_tok_valid[k+1]),
            .o_tok       (w_tok[k+1]),
            .i_upd       (w_upd)
        );
    end

    assign w_last_valid = w_tok_valid[FRAMES];
    assign w_last       = w_tok[FRAMES];

    // broadcast update to all cells
    always_comb begin
        w_upd.en        = w_apply;
        w_upd.idx       = r_idx;
        w_upd.old_valid = r_old_valid;
        w_upd.old_rank  = r_old_rank;
        w_upd.fill      = !r_hit;
        w_upd.page      = r_key;
    end

    // saturating totals
    always_comb begin
        n_fault_cnt = r_fault_cnt;
        n_hit_cnt   = r_hit_cnt;
        if (r_hit) begin
            if (r_hit_cnt != '1) begin
                n_hit_cnt = r_hit_cnt + 1'b1;
            end
        end else if (r_fault_cnt != '1) begin
            n_fault_cnt = r_fault_cnt + 1'b1;
        end
    end

    // control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
            r_fault_cnt <= '0;
            r_hit_cnt   <= '0;
        end else begin
            r_start <= w_accept;
            if (w_cfg_wr) begin
                r_cfg <= pwdata[CFG_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_last_valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end else if (w_apply) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_apply) begin
                r_out_valid <= 1'b1;
                r_fault_cnt <= n_fault_cnt;
                r_hit_cnt   <= n_hit_cnt;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: key, settled choice, result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= PAGE_BITS'(i_page);
        end
        if (w_last_valid) begin
            r_hit       <= w_last.hit_found;
            r_old_valid <= w_last.hit_found || !w_last.empty_found;
            r_old_rank  <= w_last.hit_found ? w_last.hit_rank : w_last.best_rank;
            r_ev_valid  <= !w_last.hit_found && !w_last.empty_found;
            r_ev_page   <= (!w_last.hit_found && !w_last.empty_found) ?
                           w_last.best_page : '0;
            if (w_last.hit_found) begin
                r_idx <= w_last.hit_idx;
            end else if (w_last.empty_found) begin
                r_idx <= w_last.empty_idx;
            end else begin
                r_idx <= w_last.best_idx;
            end
        end
        if (w_apply) begin
            r_out.hit           <= r_hit;
            r_out.slot          <= SLOT_W'(r_idx);
            r_out.evicted_valid <= r_ev_valid;
            r_out.evicted_page  <= PAGE_W'(r_ev_page);
            r_out.fault_total   <= n_fault_cnt;
            r_out.hit_total     <= n_hit_cnt;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out.hit;
    assign o_slot          = r_out.slot;
    assign o_evicted_valid = r_out.evicted_valid;
    assign o_evicted_page  = r_out.evicted_page;
    assign o_fault_total   = r_out.fault_total;
    assign o_hit_total     = r_out.hit_total;

    // checks
    `LRUPR_ASSERT_IMP(a_tok_only_in_scan, i_clk, i_rst_n, w_last_valid, r_state == S_SCAN)
    `LRUPR_ASSERT_NEXT(a_apply_loads_out, i_clk, i_rst_n, w_apply, r_out_valid)
    `LRUPR_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n, r_out_valid, !(r_out.hit && r_out.evicted_valid))
    `LRUPR_ASSERT_NEXT(a_hit_count_step, i_clk, i_rst_n, w_apply && r_hit && (r_hit_cnt != '1), r_hit_cnt == $past(r_hit_cnt) + 1'b1)

endmodule
